@@ rtl/srr_pkg.sv @@
`timescale 1ns / 1ps

package srr_pkg;

  localparam int LOG_TABLE_BITS = 8;
  localparam int TAB_N = 1 << LOG_TABLE_BITS;
  localparam int TAB_SHIFT = 16 - LOG_TABLE_BITS;

  // Iterations of the shared step pipeline: one quotient bit per stage,
  // one root bit per stage in the first SQ_STEPS of them.
  localparam int DIV_STEPS = 26;
  localparam int SQ_STEPS = 17;

  localparam logic [11:0] EXP_TWO  = 12'd512;
  localparam logic [11:0] EXP_FOUR = 12'd1024;
  localparam logic [11:0] EXP_FIVE = 12'd1280;

  localparam logic [1:0] MODE_CIRCULAR   = 2'd0;
  localparam logic [1:0] MODE_CONTINUOUS = 2'd1;
  localparam logic [1:0] MODE_MAC_LIKE   = 2'd2;
  localparam logic [1:0] MODE_CUSTOM     = 2'd3;

  localparam logic [2:0] REG_HALF_WIDTH     = 3'd0;
  localparam logic [2:0] REG_HALF_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_CORNER_RADIUS  = 3'd2;
  localparam logic [2:0] REG_CURVE_EXPONENT = 3'd3;
  localparam logic [2:0] REG_CURVE_MODE     = 3'd4;

  localparam logic signed [19:0] DIST_MAX = 20'sd131071;
  localparam logic signed [19:0] DIST_MIN = -20'sd131072;

  typedef logic [17:0] tab_t [0:TAB_N];
  typedef logic [17+TAB_SHIFT:0] lprod_t;

  typedef struct packed {
    logic               vld;
    logic               tab;
    logic [11:0]        p;
    logic [14:0]        r;
    logic signed [17:0] qx;
    logic signed [17:0] qy;
    logic signed [17:0] inner;
    logic [15:0]        m;
    logic [15:0]        n;
    logic [33:0]        sum;
    logic [3:0]         km;
    logic [3:0]         kn;
    logic [15:0]        fm;
    logic [15:0]        fn;
    logic [20:0]        lm;
    logic [20:0]        ln;
    logic [20:0]        d;
    logic [24:0]        dp;
    logic [9:0]         s;
    logic [15:0]        c;
    logic [16:0]        u;
    logic [17:0]        lv;
    logic [25:0]        num;
    logic [25:0]        quo;
    logic [11:0]        drem;
    logic [33:0]        sq_src;
    logic [20:0]        sq_rem;
    logic [16:0]        sq_root;
    logic [17:0]        fac;
    logic [17:0]        len;
  } pipe_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] x;
    res = 64'd0;
    bit_v = 64'd1 << 62;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > x) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 64'd0) begin
        if (x >= res + bit_v) begin
          x = x - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + i/N) in Q16 by repeated squaring
  function automatic tab_t mk_log();
    tab_t t;
    logic [63:0] y;
    logic [63:0] acc;
    for (int i = 0; i < TAB_N; i++) begin
      y = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      acc = 64'd0;
      for (int j = 0; j < 24; j++) begin
        y = (y * y) >> 30;
        acc = acc << 1;
        if (y >= (64'd1 << 31)) begin
          acc = acc | 64'd1;
          y = y >> 1;
        end
      end
      t[i] = 18'((acc + 64'd128) >> 8);
    end
    t[TAB_N] = 18'd65536;
    return t;
  endfunction

  // 2^(i/N) in Q16 from a chain of square roots of two
  function automatic tab_t mk_exp();
    tab_t t;
    logic [63:0] root [0:LOG_TABLE_BITS];
    logic [63:0] prod;
    root[0] = 64'd1 << 31;
    for (int j = 1; j <= LOG_TABLE_BITS; j++) begin
      root[j] = isqrt64(root[j-1] << 30);
    end
    for (int i = 0; i < TAB_N; i++) begin
      prod = 64'd1 << 30;
      for (int j = 0; j < LOG_TABLE_BITS; j++) begin
        if (((i >> j) & 1) != 0) begin
          prod = (prod * root[LOG_TABLE_BITS-j] + (64'd1 << 29)) >> 30;
        end
      end
      t[i] = 18'((prod + (64'd1 << 13)) >> 14);
    end
    t[TAB_N] = 18'd131072;
    return t;
  endfunction

  localparam tab_t LOG_TAB = mk_log();
  localparam tab_t EXP_TAB = mk_exp();

  function automatic logic [17:0] lerp_tab(input tab_t t, input logic [15:0] f);
    logic [LOG_TABLE_BITS-1:0] idx;
    logic [TAB_SHIFT-1:0]      wgt;
    logic [17:0]               lo;
    logic [17:0]               hi;
    logic [17:0]               diff;
    lprod_t                    prod;
    idx = f[15:TAB_SHIFT];
    wgt = f[TAB_SHIFT-1:0];
    lo = t[idx];
    hi = t[{1'b0, idx} + 1'b1];
    diff = (hi >= lo) ? hi - lo : 18'd0;
    prod = lprod_t'(diff) * lprod_t'(wgt) + lprod_t'(1 << (TAB_SHIFT - 1));
    return 18'(lo + 18'(prod >> TAB_SHIFT));
  endfunction

  function automatic logic [3:0] msb16(input logic [15:0] x);
    logic [3:0] k;
    k = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) k = 4'(i);
    end
    return k;
  endfunction

  // mantissa bits below the leading one, left aligned
  function automatic logic [15:0] mant16(input logic [15:0] x, input logic [3:0] k);
    logic [31:0] sh;
    sh = {x, 16'd0} >> k;
    return sh[15:0];
  endfunction

endpackage

@@ rtl/superellipse_rounded_rect_sdf.sv @@
`timescale 1ns / 1ps

// Signed distance from a pixel to a rounded rectangle with superellipse
// corners. Write the five setup registers through cfg_we / cfg_index /
// cfg_data while no pixel is in flight; indexes past the last register are
// dropped. Pulse start with pos_x / pos_y (signed Q11.4, relative to the
// rectangle center) to hand in one beat; busy stays low, so a beat can enter
// on every clock. Each beat yields one distance (signed Q13.4, negative
// inside) with done high for one cycle. Throughput is one pixel per clock.
// Latency is set by the step pipeline that forms one quotient bit of the
// 1/p division per stage, with the integer square root sharing its first
// stages. The receiver cannot stall: every result is shown for exactly
// one cycle. Reset clears all valid bits and loads the register defaults
// (exponent 2.0, circular mode, zero sizes).
module superellipse_rounded_rect_sdf (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  output logic               done,
  output logic signed [17:0] distance
);

  logic [14:0] half_width;
  logic [14:0] half_height;
  logic [14:0] corner_radius;
  logic [11:0] curve_exponent;
  logic [1:0]  curve_mode;

  logic [11:0] p_res;
  logic [14:0] r_res;

  srr_pkg::pipe_t s1, s2, s3, s4, s5, s6, s7, s8, s9;
  srr_pkg::pipe_t s1_next, s2_next, s3_next, s4_next, s5_next;
  srr_pkg::pipe_t s6_next, s7_next, s8_next, s9_next, s10_next;
  srr_pkg::pipe_t lp [0:srr_pkg::DIV_STEPS];
  srr_pkg::pipe_t f1, f2, f1_next, f2_next;

  logic               done_next;
  logic signed [17:0] distance_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width     <= '0;
      half_height    <= '0;
      corner_radius  <= '0;
      curve_exponent <= srr_pkg::EXP_TWO;
      curve_mode     <= srr_pkg::MODE_CIRCULAR;
    end else if (cfg_we) begin
      case (cfg_index)
        srr_pkg::REG_HALF_WIDTH:     half_width     <= cfg_data;
        srr_pkg::REG_HALF_HEIGHT:    half_height    <= cfg_data;
        srr_pkg::REG_CORNER_RADIUS:  corner_radius  <= cfg_data;
        srr_pkg::REG_CURVE_EXPONENT: curve_exponent <= cfg_data[11:0];
        srr_pkg::REG_CURVE_MODE:     curve_mode     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // resolve exponent and clamp radius
  always_comb begin
    case (curve_mode)
      srr_pkg::MODE_CIRCULAR:   p_res = srr_pkg::EXP_TWO;
      srr_pkg::MODE_CONTINUOUS:
        p_res = (curve_exponent < srr_pkg::EXP_TWO) ? srr_pkg::EXP_FOUR : curve_exponent;
      srr_pkg::MODE_MAC_LIKE:
        p_res = (curve_exponent < srr_pkg::EXP_TWO) ? srr_pkg::EXP_FIVE : curve_exponent;
      default:
        p_res = (curve_exponent < srr_pkg::EXP_TWO) ? srr_pkg::EXP_TWO : curve_exponent;
    endcase
    r_res = corner_radius;
    if (r_res > half_width) r_res = half_width;
    if (r_res > half_height) r_res = half_height;
  end

  // stage 1: per-axis offset from the inner rectangle
  always_comb begin
    logic signed [16:0] sx, sy;
    logic [16:0]        ax, ay;
    sx = {pos_x[15], pos_x};
    sy = {pos_y[15], pos_y};
    ax = (sx < 0) ? 17'(-sx) : 17'(sx);
    ay = (sy < 0) ? 17'(-sy) : 17'(sy);
    s1_next = '0;
    s1_next.vld = start & ~busy & ~rst;
    s1_next.tab = (p_res != srr_pkg::EXP_TWO);
    s1_next.p = p_res;
    s1_next.r = r_res;
    s1_next.qx = $signed({1'b0, ax}) - $signed({3'b0, half_width}) + $signed({3'b0, r_res});
    s1_next.qy = $signed({1'b0, ay}) - $signed({3'b0, half_height}) + $signed({3'b0, r_res});
  end

  // stage 2: outside parts, ordered, and the inside term
  always_comb begin
    logic [15:0]        ox, oy;
    logic signed [17:0] mx;
    s2_next = s1;
    if (rst) s2_next.vld = 1'b0;
    ox = (s1.qx > 0) ? s1.qx[15:0] : 16'd0;
    oy = (s1.qy > 0) ? s1.qy[15:0] : 16'd0;
    s2_next.m = (ox > oy) ? ox : oy;
    s2_next.n = (ox > oy) ? oy : ox;
    mx = (s1.qx > s1.qy) ? s1.qx : s1.qy;
    s2_next.inner = (mx > 0) ? 18'sd0 : mx;
  end

  // stage 3: sum of squares, normalize both parts
  always_comb begin
    s3_next = s2;
    if (rst) s3_next.vld = 1'b0;
    s3_next.sum = 34'(s2.m) * 34'(s2.m) + 34'(s2.n) * 34'(s2.n);
    s3_next.km = srr_pkg::msb16(s2.m);
    s3_next.kn = srr_pkg::msb16(s2.n);
    s3_next.fm = srr_pkg::mant16(s2.m, s3_next.km);
    s3_next.fn = srr_pkg::mant16(s2.n, s3_next.kn);
  end

  // stage 4: log2 of both parts
  always_comb begin
    s4_next = s3;
    if (rst) s4_next.vld = 1'b0;
    s4_next.lm = {1'b0, s3.km, 16'd0} + 21'(srr_pkg::lerp_tab(srr_pkg::LOG_TAB, s3.fm));
    s4_next.ln = {1'b0, s3.kn, 16'd0} + 21'(srr_pkg::lerp_tab(srr_pkg::LOG_TAB, s3.fn));
  end

  always_comb begin
    s5_next = s4;
    if (rst) s5_next.vld = 1'b0;
    s5_next.d = (s4.lm > s4.ln) ? s4.lm - s4.ln : 21'd0;
  end

  always_comb begin
    logic [32:0] prod;
    s6_next = s5;
    if (rst) s6_next.vld = 1'b0;
    prod = 33'(s5.d) * 33'(s5.p) + 33'd128;
    s6_next.dp = prod[32:8];
  end

  // split p*log into shift and fraction
  always_comb begin
    logic [25:0] t;
    s7_next = s6;
    if (rst) s7_next.vld = 1'b0;
    t = 26'(s6.dp) + 26'd65535;
    s7_next.s = t[25:16];
    s7_next.c = 16'({s7_next.s, 16'd0} - 26'(s6.dp));
  end

  // ratio raised to p
  always_comb begin
    logic [19:0] ev, rnd;
    s8_next = s7;
    if (rst) s8_next.vld = 1'b0;
    ev = 20'(srr_pkg::lerp_tab(srr_pkg::EXP_TAB, s7.c));
    rnd = (s7.s == 10'd0) ? 20'd0 : 20'(20'd1 << (s7.s - 10'd1));
    if (s7.s == 10'd0) s8_next.u = 17'd65536;
    else if (s7.s > 10'd20) s8_next.u = 17'd0;
    else s8_next.u = 17'((ev + rnd) >> s7.s);
  end

  // log2 of 1 + ratio^p
  always_comb begin
    logic [17:0] ux;
    logic [15:0] f;
    s9_next = s8;
    if (rst) s9_next.vld = 1'b0;
    ux = 18'd65536 + 18'(s8.u);
    f = ux[17] ? ux[16:1] : ux[15:0];
    s9_next.lv = {1'b0, ux[17], 16'd0} + srr_pkg::lerp_tab(srr_pkg::LOG_TAB, f);
  end

  // load both step engines
  always_comb begin
    s10_next = s9;
    if (rst) s10_next.vld = 1'b0;
    s10_next.num = {s9.lv, 8'd0} + 26'(s9.p >> 1);
    s10_next.quo = '0;
    s10_next.drem = '0;
    s10_next.sq_src = s9.sum;
    s10_next.sq_rem = '0;
    s10_next.sq_root = '0;
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
    s2 <= s2_next;
    s3 <= s3_next;
    s4 <= s4_next;
    s5 <= s5_next;
    s6 <= s6_next;
    s7 <= s7_next;
    s8 <= s8_next;
    s9 <= s9_next;
    lp[0] <= s10_next;
  end

  // one divide bit per stage, and one root bit in each of the first SQ_STEPS stages
  for (genvar g = 0; g < srr_pkg::DIV_STEPS; g++) begin : g_step
    srr_pkg::pipe_t step_next;

    always_comb begin
      logic [12:0] dt;
      logic [20:0] st, tr;
      step_next = lp[g];
      if (rst) step_next.vld = 1'b0;
      dt = {lp[g].drem, lp[g].num[25]};
      step_next.num = {lp[g].num[24:0], 1'b0};
      if (dt >= {1'b0, lp[g].p}) begin
        step_next.drem = 12'(dt - {1'b0, lp[g].p});
        step_next.quo = {lp[g].quo[24:0], 1'b1};
      end else begin
        step_next.drem = dt[11:0];
        step_next.quo = {lp[g].quo[24:0], 1'b0};
      end
      st = {lp[g].sq_rem[18:0], lp[g].sq_src[33:32]};
      tr = 21'({lp[g].sq_root, 2'b01});
      if (g < srr_pkg::SQ_STEPS) begin
        step_next.sq_src = {lp[g].sq_src[31:0], 2'b00};
        if (st >= tr) begin
          step_next.sq_rem = st - tr;
          step_next.sq_root = {lp[g].sq_root[15:0], 1'b1};
        end else begin
          step_next.sq_rem = st;
          step_next.sq_root = {lp[g].sq_root[15:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      lp[g+1] <= step_next;
    end
  end

  // root rounding and the 1/p power factor
  always_comb begin
    logic [15:0] w;
    f1_next = lp[srr_pkg::DIV_STEPS];
    if (rst) f1_next.vld = 1'b0;
    w = (lp[srr_pkg::DIV_STEPS].quo[25:16] != 10'd0) ? 16'hFFFF
                                                     : lp[srr_pkg::DIV_STEPS].quo[15:0];
    f1_next.fac = srr_pkg::lerp_tab(srr_pkg::EXP_TAB, w);
    f1_next.len = 18'(lp[srr_pkg::DIV_STEPS].sq_root)
                + ((lp[srr_pkg::DIV_STEPS].sq_rem > 21'(lp[srr_pkg::DIV_STEPS].sq_root))
                   ? 18'd1 : 18'd0);
  end

  always_comb begin
    logic [33:0] prod;
    f2_next = f1;
    if (rst) f2_next.vld = 1'b0;
    prod = 34'(f1.m) * 34'(f1.fac) + 34'd32768;
    if (f1.tab) begin
      if (f1.m == 16'd0) f2_next.len = 18'd0;
      else if (f1.n == 16'd0) f2_next.len = {2'b00, f1.m};
      else f2_next.len = prod[33:16];
    end
  end

  always_comb begin
    logic signed [19:0] dsum;
    dsum = $signed({2'b00, f2.len}) + 20'(f2.inner) - $signed({5'b0, f2.r});
    done_next = f2.vld;
    if (dsum > srr_pkg::DIST_MAX) distance_next = 18'(srr_pkg::DIST_MAX);
    else if (dsum < srr_pkg::DIST_MIN) distance_next = 18'(srr_pkg::DIST_MIN);
    else distance_next = dsum[17:0];
  end

  always_ff @(posedge clk) begin
    f1 <= f1_next;
    f2 <= f2_next;
    distance <= distance_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
  end

endmodule
